/* src/assert_macros.svh */
// Assertion helpers for the WAV parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

/* src/rwp_pkg.sv */
// ----------------------------------------------------------------------------
// rwp_pkg
// Shared constants and types for the WAV chunk parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rwp_pkg;
  localparam int unsigned OffsetBits = 33;
  localparam logic [31:0] TagRiff = 32'h52494646;
  localparam logic [31:0] TagWave = 32'h57415645;
  localparam logic [31:0] TagFmt  = 32'h666D7420;
  localparam logic [31:0] TagData = 32'h64617461;

  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StHeader = 3'd1;
  localparam logic [2:0] StBounds = 3'd2;
  localparam logic [2:0] StNotPcm = 3'd3;
  localparam logic [2:0] StAudio  = 3'd4;

  localparam logic [2:0] PhRiff = 3'd0;
  localparam logic [2:0] PhHdr  = 3'd1;
  localparam logic [2:0] PhBody = 3'd2;
  localparam logic [2:0] PhIdle = 3'd3;

  localparam logic [1:0] KindOther = 2'd0;
  localparam logic [1:0] KindFmt   = 2'd1;
  localparam logic [1:0] KindData  = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic step;   // consume the byte held in the input register
    logic clear;  // return to reset state after the summary
  } rwp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic data_out;   // the byte is an audio word
    logic [2:0] st;   // summary status after this byte
  } rwp_sts_t;
endpackage
`default_nettype wire

/* src/rwp_datapath.sv */
// ----------------------------------------------------------------------------
// rwp_datapath
// Header and chunk walk registers, updated once per byte on command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rwp_datapath import rwp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire rwp_cmd_t   cmd_i,
  input  wire logic [7:0] byte_i,
  output rwp_sts_t        sts_o,
  output logic [15:0]     ch_o,
  output logic [31:0]     rate_o,
  output logic [15:0]     depth_o,
  output logic [31:0]     len_o
);
  localparam logic [OffsetBits-1:0] PosMax = '1;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [31:0] sh_q, sh_d;
  logic [32:0] lim_q, lim_d, left_q, left_d, idx_q, idx_d;
  logic bad_q, bad_d, fseen_q, fseen_d;
  logic [2:0] ph_q, ph_d, err_q, err_d;
  logic [1:0] kind_q, kind_d;
  logic [15:0] ch_q, ch_d, dep_q, dep_d;
  logic [31:0] rate_q, rate_d, dsz_q, dsz_d;
  logic dout;

  logic [31:0] sw32;
  logic [15:0] sw16;
  logic [33:0] p34, start, room, size, padded, lim34;
  logic [33:0] pnext;
  logic [OffsetBits-1:0] pos_n;

  assign sw32 = {sh_d[7:0], sh_d[15:8], sh_d[23:16], sh_d[31:24]};
  assign sw16 = {sh_d[7:0], sh_d[15:8]};

  always_comb begin
    sh_d = {sh_q[23:0], byte_i};
    pos_d = pos_q; lim_d = lim_q; left_d = left_q; idx_d = idx_q;
    bad_d = bad_q; fseen_d = fseen_q; ph_d = ph_q; err_d = err_q; kind_d = kind_q;
    ch_d = ch_q; dep_d = dep_q; rate_d = rate_q; dsz_d = dsz_q;
    dout = 1'b0;
    p34 = 34'(pos_q);
    start = p34 + 34'd1;
    lim34 = {1'b0, lim_q};
    room = (lim34 >= start) ? lim34 - start : 34'd0;
    size = {2'b0, sw32};
    padded = size + {33'd0, sw32[0]};
    pnext = p34 + 34'd1;
    case (ph_q)
      PhRiff: begin
        if (p34 == 34'd3 && sh_d != TagRiff) bad_d = 1'b1;
        if (p34 == 34'd7) lim_d = {1'b0, sw32} + 33'd8;
        if (p34 == 34'd11) begin
          if (sh_d != TagWave || lim_q < 33'd12) bad_d = 1'b1;
          if (bad_d) ph_d = PhIdle;
          else if (34'd20 <= lim34) begin ph_d = PhHdr; left_d = 33'd8; end
          else ph_d = PhIdle;
        end
      end
      PhHdr: begin
        left_d = left_q - 33'd1;
        if (left_d == 33'd4) begin
          kind_d = (sh_d == TagFmt) ? KindFmt : ((sh_d == TagData) ? KindData : KindOther);
        end else if (left_d == 33'd0) begin
          if (size > room) begin err_d = StBounds; ph_d = PhIdle; end
          else if (kind_q == KindFmt && size < 34'd16) begin
            err_d = StNotPcm; ph_d = PhIdle;
          end else if (kind_q != KindFmt && padded > room) begin
            err_d = StBounds; ph_d = PhIdle;
          end else begin
            if (kind_q != KindFmt) begin
              if (kind_q == KindData && dsz_q == 32'd0 && sw32 != 32'd0) dsz_d = sw32;
              else kind_d = KindOther;
            end
            left_d = padded[32:0];
            idx_d = '0;
            ph_d = PhBody;
            if (padded == 34'd0) begin
              if (start + 34'd8 <= lim34) begin ph_d = PhHdr; left_d = 33'd8; end
              else ph_d = PhIdle;
            end
          end
        end
      end
      PhBody: begin
        dout = (kind_q == KindData) && (idx_q < {1'b0, dsz_q});
        if (kind_q == KindFmt && idx_q == 33'd1 && sw16 != 16'd1) begin
          err_d = StNotPcm; ph_d = PhIdle;
        end else if (kind_q == KindFmt && idx_q == 33'd1 &&
                     p34 + {1'b0, left_q} > lim34) begin
          err_d = StBounds; ph_d = PhIdle;
        end else begin
          if (kind_q == KindFmt) begin
            if (idx_q == 33'd1) fseen_d = 1'b1;
            if (idx_q == 33'd3) ch_d = sw16;
            if (idx_q == 33'd7) rate_d = sw32;
            if (idx_q == 33'd15) dep_d = sw16;
          end
          left_d = left_q - 33'd1;
          idx_d = idx_q + 33'd1;
          if (left_d == 33'd0) begin
            if (pnext + 34'd8 <= lim34) begin ph_d = PhHdr; left_d = 33'd8; end
            else ph_d = PhIdle;
          end
        end
      end
      default: ;
    endcase
    pos_n = (pos_q < PosMax) ? pos_q + 1'b1 : PosMax;
    pos_d = pos_n;
  end

  // Summary status, judged on the post-byte state. The remainder of the data
  // size by twice the channel count is left to the controller's serial unit.
  logic [OffsetBits-1:0] sz;
  assign sz = pos_d;
  logic hdr_fail, audio_fail, mod_fail;
  logic [32:0] div2;
  logic [2:0] st_w;
  assign div2 = {16'd0, ch_d, 1'b0};
  // Remainder is computed by the controller's serial unit; here only the
  // non-arithmetic parts.
  assign hdr_fail = bad_d || (34'(sz) < 34'd12) || (34'(lim_d) > 34'(sz)) || (ph_d != PhIdle);
  assign audio_fail = !fseen_d || ch_d == 16'd0 || rate_d == 32'd0 ||
                      dep_d != 16'd16 || dsz_d == 32'd0;
  assign mod_fail = (div2 == 33'd0);

  always_comb begin
    if (hdr_fail) st_w = StHeader;
    else if (err_d != StOk) st_w = err_d;
    else if (audio_fail || mod_fail) st_w = StAudio;
    else st_w = StOk;
  end
  assign sts_o = {dout, st_w};
  assign ch_o = ch_d;
  assign rate_o = rate_d;
  assign depth_o = dep_d;
  assign len_o = dsz_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; sh_q <= '0; lim_q <= '0; left_q <= '0; idx_q <= '0;
      bad_q <= 1'b0; fseen_q <= 1'b0; ph_q <= PhRiff; err_q <= StOk; kind_q <= KindOther;
      ch_q <= '0; dep_q <= '0; rate_q <= '0; dsz_q <= '0;
    end else if (cmd_i.clear) begin
      pos_q <= '0; sh_q <= '0; lim_q <= '0; left_q <= '0; idx_q <= '0;
      bad_q <= 1'b0; fseen_q <= 1'b0; ph_q <= PhRiff; err_q <= StOk; kind_q <= KindOther;
      ch_q <= '0; dep_q <= '0; rate_q <= '0; dsz_q <= '0;
    end else if (cmd_i.step) begin
      pos_q <= pos_d; sh_q <= sh_d; lim_q <= lim_d; left_q <= left_d; idx_q <= idx_d;
      bad_q <= bad_d; fseen_q <= fseen_d; ph_q <= ph_d; err_q <= err_d; kind_q <= kind_d;
      ch_q <= ch_d; dep_q <= dep_d; rate_q <= rate_d; dsz_q <= dsz_d;
    end
  end
endmodule
`default_nettype wire

/* src/rwp_ctrl.sv */
// ----------------------------------------------------------------------------
// rwp_ctrl
// Sequencer: input register, byte step, result words and the final
// remainder check carried out bit-serially.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rwp_ctrl import rwp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_final_i,
  output logic [7:0]       byte_o,
  output rwp_cmd_t         cmd_o,
  input  wire rwp_sts_t    sts_i,
  input  wire logic [15:0] ch_i,
  input  wire logic [31:0] rate_i,
  input  wire logic [15:0] depth_i,
  input  wire logic [31:0] len_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [108:0]     out_word_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SStep = 3'd1;
  localparam logic [2:0] SDiv  = 3'd2;
  localparam logic [2:0] SSum  = 3'd3;
  localparam logic [2:0] SWait = 3'd4;

  logic [2:0] s_q, s_d;
  logic [7:0] b_q;
  logic fin_q;
  logic [2:0] st_q;
  logic [15:0] ch_q; logic [31:0] rate_q; logic [15:0] dep_q; logic [31:0] len_q;
  logic [32:0] rem_q;
  logic [31:0] quo_q;
  logic [5:0] cnt_q;
  logic ov_q;
  logic [108:0] ow_q;
  logic [32:0] dv;
  logic [32:0] trial;

  assign dv = {16'd0, ch_q, 1'b0};
  assign trial = {rem_q[31:0], quo_q[31]};
  assign byte_o = b_q;
  assign in_ready_o = (s_q == SIdle) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_word_o = ow_q;

  always_comb begin
    cmd_o.step = (s_q == SStep);
    cmd_o.clear = (s_q == SSum) && !ov_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= SIdle; ov_q <= 1'b0; cnt_q <= '0; fin_q <= 1'b0; st_q <= StOk;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (s_q)
        SIdle: if (in_valid_i && !ov_q) begin
          b_q <= in_byte_i; fin_q <= in_final_i; s_q <= SStep;
        end
        SStep: begin
          st_q <= sts_i.st; ch_q <= ch_i; rate_q <= rate_i; dep_q <= depth_i; len_q <= len_i;
          if (sts_i.data_out) begin
            ov_q <= 1'b1;
            ow_q <= {1'b0, 32'd0, 16'd0, 32'd0, 16'd0, StOk, b_q, 1'b0};
          end
          if (fin_q) begin
            s_q <= SDiv; rem_q <= '0; quo_q <= len_i; cnt_q <= 6'd32;
          end else s_q <= sts_i.data_out ? SWait : SIdle;
        end
        SWait: if (!ov_q || out_ready_i) s_q <= SIdle;
        SDiv: begin
          if (st_q != StOk || cnt_q == 6'd0) s_q <= SSum;
          else begin
            rem_q <= (trial >= dv) ? trial - dv : trial;
            quo_q <= {quo_q[30:0], 1'b0};
            cnt_q <= cnt_q - 6'd1;
          end
        end
        SSum: if (!ov_q) begin
          ov_q <= 1'b1;
          if (st_q == StOk && rem_q == 33'd0)
            ow_q <= {1'b1, len_q, dep_q, rate_q, ch_q, StOk, 8'd0, 1'b1};
          else
            ow_q <= {1'b1, 32'd0, 16'd0, 32'd0, 16'd0,
                     (st_q == StOk) ? StAudio : st_q, 8'd0, 1'b1};
          s_q <= SIdle;
        end
        default: s_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/riff_wav_pcm16_chunk_parser.sv */
// ----------------------------------------------------------------------------
// riff_wav_pcm16_chunk_parser
// WAV header and chunk walker for 16-bit PCM payloads.
// ----------------------------------------------------------------------------
// Usage: payload bytes enter on the s_axis group, one byte per word, with
// tlast marking the final byte. Results leave on the m_axis group: tuser is
// the item kind (0 audio byte, 1 summary) and tdata carries the remaining
// fields. An audio word is produced for every body byte of the first
// non-empty data chunk; the final byte also yields a summary word with the
// status and, when it is good, the format fields and data length.
// Each byte is handled by the controller in turn: it is registered, then
// stepped, and one that yields an audio word then waits until that word is
// taken; no new byte is taken before that. An audio word is loaded into the
// output register in the step state of its byte. The final byte adds a
// bit-serial remainder check, skipped when the status is already bad, and a
// state that loads the summary once the output register is free. Results are
// held in one output register: while it is stalled no further byte is
// taken. Reset, asynchronous and active low, returns the parser to the RIFF
// header phase with no error; after each summary the block clears itself
// ready for the next payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module riff_wav_pcm16_chunk_parser import rwp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // payload_byte
  input  wire logic         s_axis_tlast,   // final_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // audio_byte, status_code, channel_count, sample_rate_hz, bits_per_sample,
  // audio_length, then zero fill
  output logic [111:0]      m_axis_tdata,
  output logic              m_axis_tuser,   // item_kind
  output logic              m_axis_tlast    // end_of_run
);
  rwp_cmd_t cmd;
  rwp_sts_t sts;
  logic [7:0] byte_w;
  logic [15:0] ch; logic [31:0] rate; logic [15:0] dep; logic [31:0] len;
  logic [108:0] ow;

  rwp_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .byte_i(byte_w), .sts_o(sts),
    .ch_o(ch), .rate_o(rate), .depth_o(dep), .len_o(len)
  );

  rwp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_byte_i(s_axis_tdata), .in_final_i(s_axis_tlast), .byte_o(byte_w),
    .cmd_o(cmd), .sts_i(sts), .ch_i(ch), .rate_i(rate), .depth_i(dep), .len_i(len),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_word_o(ow)
  );

  // Word layout: bit 0 kind, then byte, status, formats, length, end flag.
  assign m_axis_tuser = ow[0];
  assign m_axis_tdata = {5'd0, ow[107:1]};
  assign m_axis_tlast = ow[108];

  // A summary always ends the run, an audio word never does.
  `ASSERT_IMPL(a_kind_last, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser == m_axis_tlast)
  // Audio words carry no status.
  `ASSERT_IMPL(a_audio_ok, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser,
               m_axis_tdata[10:8] == StOk)
  // No byte is taken while a result is pending.
  `ASSERT_IMPL(a_no_take, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
endmodule
`default_nettype wire
